// ----- hw/rtl/rth_pkg.sv -----
// Shared types and constants of the RGB to HSV converter.
`default_nettype none

package rth_pkg;

  // Number of division cells: one quotient bit per cell.
  localparam int unsigned DivSteps = 16;
  // Width of the dividend part that is shifted through the cells.
  localparam int unsigned DvdW = 16;
  // Width of the partial remainder and of the divisor (at most 510).
  localparam int unsigned RemW = 9;

  // Hue sector offset in units of 60 degrees times the spread.
  // The wrap case is the red sector with a negative difference.
  typedef enum logic [1:0] {
    OffRed   = 2'd0,
    OffGreen = 2'd1,
    OffBlue  = 2'd2,
    OffWrap  = 2'd3
  } rth_offset_e;

  // First preparation stage: extremes, sector and signed difference.
  typedef struct packed {
    logic [7:0]  brightness;
    logic [7:0]  spread;
    rth_offset_e offset;
    logic [8:0]  diff;
  } rth_sect_t;

  // State that one division cell holds and hands to its neighbor.
  typedef struct packed {
    logic [RemW-1:0] hue_rem;
    logic [DvdW-1:0] hue_dvd;
    logic [RemW-1:0] hue_dvs;
    logic            hue_zero;
    logic [RemW-1:0] sat_rem;
    logic [DvdW-1:0] sat_dvd;
    logic [RemW-1:0] sat_dvs;
    logic            sat_zero;
    logic [7:0]      brightness;
  } rth_cell_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rth_pix_if.sv -----
// Stream interface that carries one RGB pixel item.
`default_nettype none

interface rth_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rth_hsv_if.sv -----
// Stream interface that carries one HSV result item.
`default_nettype none

interface rth_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rth_prep.sv -----
// Two-stage front end that forms the dividends and divisors of hue and saturation.
`default_nettype none

module rth_prep
  import rth_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rth_cell_t      out_data_o
);

  logic      sect_valid_q;
  logic      sect_ready;
  rth_sect_t sect_d;
  rth_sect_t sect_q;
  logic      cell_valid_q;
  rth_cell_t cell_d;
  rth_cell_t cell_q;

  logic [7:0]  mn;
  logic [10:0] ks;
  logic [11:0] sum_w;
  logic [10:0] sum_pos;
  logic [22:0] hue_num;
  logic [23:0] hue_dividend;

  // Each stage takes a new item when it is empty or its item moves on.
  assign sect_ready  = !cell_valid_q || out_ready_i;
  assign in_ready_o  = !sect_valid_q || sect_ready;
  assign out_valid_o = cell_valid_q;
  assign out_data_o  = cell_q;

  // Largest channel with ties to red, then green; smallest channel.
  always_comb begin
    mn = red_i;
    if (green_i < mn) begin
      mn = green_i;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end
    priority if (red_i >= green_i && red_i >= blue_i) begin
      sect_d.brightness = red_i;
      sect_d.diff       = {1'b0, green_i} - {1'b0, blue_i};
      sect_d.offset     = sect_d.diff[8] ? OffWrap : OffRed;
    end else if (green_i >= blue_i) begin
      sect_d.brightness = green_i;
      sect_d.diff       = {1'b0, blue_i} - {1'b0, red_i};
      sect_d.offset     = OffGreen;
    end else begin
      sect_d.brightness = blue_i;
      sect_d.diff       = {1'b0, red_i} - {1'b0, green_i};
      sect_d.offset     = OffBlue;
    end
    sect_d.spread = sect_d.brightness - mn;
  end

  // Sector offset times the spread, plus the difference; the wrap adds a full turn.
  always_comb begin
    unique case (sect_q.offset)
      OffRed:   ks = 11'd0;
      OffGreen: ks = {2'b00, sect_q.spread, 1'b0};
      OffBlue:  ks = {1'b0, sect_q.spread, 2'b00};
      OffWrap:  ks = {1'b0, sect_q.spread, 2'b00} + {2'b00, sect_q.spread, 1'b0};
      default:  ks = 11'd0;
    endcase
    sum_w   = {1'b0, ks} + {{3{sect_q.diff[8]}}, sect_q.diff};
    sum_pos = sum_w[10:0];
    // Times 3840 as 4096 minus 256.
    hue_num      = {sum_pos, 12'd0} - {4'd0, sum_pos, 8'd0};
    hue_dividend = {hue_num, 1'b0} + {16'd0, sect_q.spread};

    cell_d.hue_rem    = {1'b0, hue_dividend[23:16]};
    cell_d.hue_dvd    = hue_dividend[15:0];
    cell_d.hue_dvs    = {sect_q.spread, 1'b0};
    cell_d.hue_zero   = (sect_q.spread == 8'd0);
    cell_d.sat_rem    = {1'b0, sect_q.spread};
    cell_d.sat_dvd    = {8'd0, sect_q.brightness};
    cell_d.sat_dvs    = {sect_q.brightness, 1'b0};
    cell_d.sat_zero   = (sect_q.brightness == 8'd0);
    cell_d.brightness = sect_q.brightness;
  end

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sect_valid_q <= 1'b0;
      cell_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        sect_valid_q <= in_valid_i;
      end
      if (sect_ready) begin
        cell_valid_q <= sect_valid_q;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sect_q <= sect_d;
    end
    if (sect_valid_q && sect_ready) begin
      cell_q <= cell_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rth_div_cell.sv -----
// One restoring division cell: a quotient bit of hue and of saturation per item.
`default_nettype none

module rth_div_cell
  import rth_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rth_cell_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rth_cell_t      out_data_o
);

  logic      valid_q;
  rth_cell_t data_d;
  rth_cell_t data_q;
  logic [RemW+DvdW-1:0] hue_next;
  logic [RemW+DvdW-1:0] sat_next;

  // Shift the next dividend bit into the remainder and subtract the divisor if it fits.
  function automatic logic [RemW+DvdW-1:0] lane_step(
    input logic [RemW-1:0] rem,
    input logic [DvdW-1:0] dvd,
    input logic [RemW-1:0] dvs
  );
    logic [RemW:0] trial;
    logic [RemW:0] rest;
    logic          take;
    trial = {rem, dvd[DvdW-1]};
    rest  = trial - {1'b0, dvs};
    take  = (trial >= {1'b0, dvs});
    lane_step = {(take ? rest[RemW-1:0] : trial[RemW-1:0]), dvd[DvdW-2:0], take};
  endfunction

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Step both lanes; the quotient bits fill the dividend from the bottom.
  always_comb begin
    hue_next = lane_step(in_data_i.hue_rem, in_data_i.hue_dvd, in_data_i.hue_dvs);
    sat_next = lane_step(in_data_i.sat_rem, in_data_i.sat_dvd, in_data_i.sat_dvs);
    data_d         = in_data_i;
    data_d.hue_rem = hue_next[RemW+DvdW-1:DvdW];
    data_d.hue_dvd = hue_next[DvdW-1:0];
    data_d.sat_rem = sat_next[RemW+DvdW-1:DvdW];
    data_d.sat_dvd = sat_next[DvdW-1:0];
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front end, division cell chain and output.
`default_nettype none

// Converts one 8-bit RGB pixel item per clock, unless the output holds it back,
// into hue (1/64 degree, 0..23039), saturation (32768 is 1.0) and brightness
// (the largest channel), both divisions rounded half up. Each item passes
// through two front-end stages that find the sector and form the dividends,
// then a chain of 16 division cells that each settle one quotient bit of hue and
// of saturation. Every stage has its own valid flag, so the block keeps taking
// items while a finished result waits at the output, until the chain is full.
module rgb_to_hsv_converter
  import rth_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rth_pix_if.sink   pix_i,
  rth_hsv_if.source hsv_o
);

  rth_cell_t         cell_data [DivSteps+1];
  logic [DivSteps:0] cell_valid;
  logic [DivSteps:0] cell_ready;
  rth_cell_t         last;

  // Front end.
  rth_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .out_valid_o (cell_valid[0]),
    .out_ready_i (cell_ready[0]),
    .out_data_o  (cell_data[0])
  );

  // Chain of division cells.
  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[i]),
      .in_ready_o  (cell_ready[i]),
      .in_data_i   (cell_data[i]),
      .out_valid_o (cell_valid[i+1]),
      .out_ready_i (cell_ready[i+1]),
      .out_data_o  (cell_data[i+1])
    );
  end

  // Result item; a grey pixel has no hue and a black pixel no saturation.
  assign last               = cell_data[DivSteps];
  assign cell_ready[DivSteps] = hsv_o.ready;
  assign hsv_o.valid        = cell_valid[DivSteps];
  assign hsv_o.hue          = last.hue_zero ? 15'd0 : last.hue_dvd[14:0];
  assign hsv_o.saturation   = last.sat_zero ? 16'd0 : last.sat_dvd;
  assign hsv_o.brightness   = last.brightness;

`ifndef NO_ASSERTIONS
  // Hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> hsv_o.hue < 15'd23040)
    else $error("hue beyond a full turn");

  // Saturation never exceeds one.
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> hsv_o.saturation <= 16'd32768)
    else $error("saturation above one");

  // Zero saturation means a grey pixel, which has zero hue.
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && hsv_o.saturation == 16'd0) |-> hsv_o.hue == 15'd0)
    else $error("grey pixel with nonzero hue");

  // A black pixel has neither hue nor saturation.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && hsv_o.brightness == 8'd0) |->
      (hsv_o.saturation == 16'd0 && hsv_o.hue == 15'd0))
    else $error("black pixel with hue or saturation");

  // With the output empty, every stage can move, so the input is open.
  a_open_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_o.valid |-> pix_i.ready)
    else $error("input blocked while output is empty");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_rgb_to_hsv_converter.sv -----
// Self-checking testbench of the RGB to HSV converter with its own HSV predictor.
`default_nettype none

module tb_rgb_to_hsv_converter
  import rth_pkg::*;
;

  localparam int unsigned Latency     = 18;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned BurstItems  = 40;
  localparam int unsigned HueSector   = 3840;
  localparam int unsigned HueTurn     = 23040;
  localparam int unsigned SatOne      = 32768;

  // One converted pixel as the block presents it.
  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;
  } hsv_t;

  // Predicts the HSV of every accepted pixel and checks the results in order.
  class hsv_ledger;
    hsv_t        expected_hsv[$];
    int unsigned pixels_in;
    int unsigned results_ok;
    int unsigned grey_pixels;
    int unsigned wrapped_hues;
    int unsigned mismatches;

    function new();
      pixels_in    = 0;
      results_ok   = 0;
      grey_pixels  = 0;
      wrapped_hues = 0;
      mismatches   = 0;
    endfunction

    // Exact integer conversion with round half up on both divisions.
    function hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int          mx;
      int          mn;
      int          spread;
      int          base;
      int          diff;
      int          sum;
      int          num;
      rth_offset_e sector;
      hsv_t        res;
      mx = int'(r);
      mn = int'(r);
      if (int'(g) > mx) mx = int'(g);
      if (int'(b) > mx) mx = int'(b);
      if (int'(g) < mn) mn = int'(g);
      if (int'(b) < mn) mn = int'(b);
      spread = mx - mn;
      res = '0;
      res.brightness = mx[7:0];
      if (mx > 0) res.saturation = 16'((2 * SatOne * spread + mx) / (2 * mx));
      if (spread == 0) begin
        grey_pixels++;
      end else begin
        // Ties for the largest channel go to red, then green, then blue.
        if (mx == int'(r)) begin
          sector = OffRed;
          diff   = int'(g) - int'(b);
        end else if (mx == int'(g)) begin
          sector = OffGreen;
          diff   = int'(b) - int'(r);
        end else begin
          sector = OffBlue;
          diff   = int'(r) - int'(g);
        end
        case (sector)
          OffGreen: base = 2;
          OffBlue:  base = 4;
          default:  base = 0;
        endcase
        sum = base * spread + diff;
        // A negative angle wraps around by a full turn.
        if (sum < 0) begin
          sector = OffWrap;
          wrapped_hues++;
          num = HueTurn * spread + HueSector * sum;
        end else begin
          num = HueSector * sum;
        end
        res.hue = 15'((2 * num + spread) / (2 * spread));
      end
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      expected_hsv.push_back(convert_pixel(r, g, b));
      pixels_in++;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_hsv(hsv_t got);
      hsv_t want;
      if (expected_hsv.size() == 0) begin
        report($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                         got.hue, got.saturation, got.brightness));
      end else begin
        want = expected_hsv.pop_front();
        if (got.hue !== want.hue)
          report($sformatf("hue %0d, expected %0d", got.hue, want.hue));
        if (got.saturation !== want.saturation)
          report($sformatf("saturation %0d, expected %0d", got.saturation, want.saturation));
        if (got.brightness !== want.brightness)
          report($sformatf("brightness %0d, expected %0d", got.brightness, want.brightness));
        if (got === want) results_ok++;
      end
    endtask

    function int unsigned pending();
      return expected_hsv.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned cycles;
  bit          no_idle;
  bit          hold_req;
  hsv_ledger   ledger = new();

  rth_pix_if pix ();
  rth_hsv_if hsv ();

  rgb_to_hsv_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  // Clock with a period of four time units.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter that stops a run that hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               ledger.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitor of both channels: note accepted pixels and check accepted results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hsv.valid && hsv.ready)
        ledger.check_hsv('{hue: hsv.hue, saturation: hsv.saturation,
                           brightness: hsv.brightness});
      if (pix.valid && pix.ready) ledger.note_pixel(pix.red, pix.green, pix.blue);
    end
  end

  // Result receiver: random stalls per item, and one long hold on request.
  initial begin
    int unsigned stall;
    hsv.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    hsv.ready <= 1'b1;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hsv.ready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
        hsv.ready <= 1'b1;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          hsv.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          hsv.ready <= 1'b1;
        end
      end
      @(posedge clk_i);
      while (!(hsv.valid && hsv.ready)) @(posedge clk_i);
    end
  end

  // Offers one pixel after a random gap and waits until it is accepted.
  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  // Channel byte biased toward the extremes now and then.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 8'd0;
          1:       return 8'd1;
          2:       return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random pixel: mostly independent channels, some greys and some ties.
  task send_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = pick_channel();
    g = pick_channel();
    b = pick_channel();
    case ($urandom_range(0, 9))
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: b = r;
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  // Lets the block run until every expected result has come back.
  task drain();
    pix.valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk_i);
  endtask

  // Stimulus: directed corners, random traffic, a long output hold and a no-idle stretch.
  initial begin
    cycles    = 0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    rst_ni    <= 1'b0;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Black, white, greys, pure colors, ties, the hue wrap and the smallest spreads.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd254, 8'd255);
    send_pixel(8'd1,   8'd255, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd3,   8'd2,   8'd1);
    drain();

    // Random traffic with idling on both sides.
    repeat (300) send_random_pixel();

    // Hold the output while pixels keep coming, so the pipeline fills and stalls.
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (BurstItems) send_random_pixel();
    no_idle = 1'b0;
    drain();

    // A stretch with no idling on either side.
    no_idle = 1'b1;
    repeat (150) send_random_pixel();
    no_idle = 1'b0;

    repeat (260) send_random_pixel();
    drain();
    repeat (Latency + 4) @(posedge clk_i);

    if (ledger.pending() > 0)
      ledger.report($sformatf("%0d results never arrived", ledger.pending()));
    $display("Converted %0d pixels, matched %0d results, %0d greys, %0d wrapped hues,",
             ledger.pixels_in, ledger.results_ok, ledger.grey_pixels, ledger.wrapped_hues);
    $display("under random stalls, a %0d-cycle output hold and a stretch at full rate.",
             HoldCycles);
    if (ledger.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
